// File: rtl/dhcp_pkg.sv
package dhcp_pkg;

  localparam int MaxPacketBytes = 2048;
  localparam int OffW = $clog2(MaxPacketBytes + 1);

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] OUT_DISCOVER = 2'd0;
  localparam logic [1:0] OUT_REQUEST  = 2'd1;
  localparam logic [1:0] OUT_LEASE    = 2'd2;
  localparam logic [1:0] OUT_FAILED   = 2'd3;

  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_END       = 8'd255;
  localparam logic [7:0] OPT_MASK      = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_NAME_SRV  = 8'd6;
  localparam logic [7:0] OPT_MTU       = 8'd26;
  localparam logic [7:0] OPT_BCAST     = 8'd28;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER    = 8'd54;
  localparam logic [7:0] OPT_RENEW     = 8'd58;
  localparam logic [7:0] OPT_REBIND    = 8'd59;

  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK   = 8'd5;
  localparam logic [7:0] MSG_NAK   = 8'd6;

  localparam logic [7:0] UDP_PROTO   = 8'd17;
  localparam logic [7:0] BOOTPC_PORT = 8'd68;

  typedef enum logic [2:0] {
    ST_NONE, ST_DISCOVER, ST_REQUEST, ST_DONE, ST_FAIL
  } client_state_t;

  typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_DATA} opt_phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] offered_ip;
    logic [31:0] net_mask;
    logic [31:0] router_ip;
    logic [31:0] broadcast_ip;
    logic [31:0] server_ip;
    logic [31:0] name_server_ip;
    logic [31:0] lease_seconds;
    logic [31:0] renew_seconds;
    logic [31:0] rebind_seconds;
    logic [15:0] link_mtu;
  } out_item_t;

  // Verdict of the parser on the final byte of a packet.
  typedef struct packed {
    logic       pkt_end;
    logic       accepted;
    logic [7:0] kind;
  } pkt_status_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0: m = 8'h63;
      2'd1: m = 8'h82;
      2'd2: m = 8'h53;
      default: m = 8'h63;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/dhcp_byte_parser.sv
module dhcp_byte_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output dhcp_pkg::pkt_status_t  status,
  output dhcp_pkg::out_item_t    lease
);
  import dhcp_pkg::*;

  logic [OffW-1:0] off_r, off_nxt;
  logic [3:0]      hw_r, hw_nxt;
  logic [15:0]     tlen_r, tlen_nxt;
  logic            hok_r, hok_nxt;
  opt_phase_t      ph_r, ph_nxt;
  logic [7:0]      code_r, code_nxt;
  logic [7:0]      rem_r, rem_nxt;
  logic [31:0]     shift_r, shift_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [31:0]     cap_r [9];
  logic [31:0]     cap_nxt [9];
  logic            ns_r, ns_nxt;
  logic [31:0]     yip_r, yip_nxt;
  logic [7:0]      kind_r, kind_nxt;
  logic            end_r, end_nxt;

  logic [OffW-1:0] o, ipl, rel;
  logic [7:0]      b;
  logic [31:0]     sh;
  logic [2:0]      cn;
  logic [2:0]      sz;
  logic [3:0]      slot;
  logic            ok;

  always_comb begin
    case (code_r)
      OPT_MASK:     begin slot = 4'd0; sz = 3'd4; end
      OPT_ROUTER:   begin slot = 4'd1; sz = 3'd4; end
      OPT_BCAST:    begin slot = 4'd2; sz = 3'd4; end
      OPT_SERVER:   begin slot = 4'd3; sz = 3'd4; end
      OPT_NAME_SRV: begin slot = 4'd4; sz = 3'd4; end
      OPT_LEASE:    begin slot = 4'd5; sz = 3'd4; end
      OPT_RENEW:    begin slot = 4'd6; sz = 3'd4; end
      OPT_REBIND:   begin slot = 4'd7; sz = 3'd4; end
      OPT_MTU:      begin slot = 4'd8; sz = 3'd2; end
      OPT_MSG_TYPE: begin slot = 4'd9; sz = 3'd1; end
      default:      begin slot = 4'd9; sz = 3'd0; end
    endcase
  end

  always_comb begin
    o = off_r;
    b = data_byte;
    off_nxt = off_r; hw_nxt = hw_r; tlen_nxt = tlen_r; hok_nxt = hok_r;
    ph_nxt = ph_r; code_nxt = code_r; rem_nxt = rem_r; shift_nxt = shift_r;
    cnt_nxt = cnt_r; ns_nxt = ns_r; yip_nxt = yip_r; kind_nxt = kind_r;
    end_nxt = end_r;
    for (int i = 0; i < 9; i++) cap_nxt[i] = cap_r[i];
    sh = '0; cn = '0;
    if (o == OffW'(0)) hw_nxt = b[3:0];
    ipl = OffW'({hw_nxt, 2'b00});
    rel = o - ipl;
    if (step && o < OffW'(MaxPacketBytes)) begin
      if (o == OffW'(2)) tlen_nxt = {b, 8'h00};
      if (o == OffW'(3)) tlen_nxt = {tlen_r[15:8], b};
      if (o == OffW'(9) && b != UDP_PROTO) hok_nxt = 1'b0;
      if (o >= ipl) begin
        if (rel == OffW'(2) && b != 8'h00) hok_nxt = 1'b0;
        if (rel == OffW'(3) && b != BOOTPC_PORT) hok_nxt = 1'b0;
        if (rel >= OffW'(24) && rel < OffW'(28)) yip_nxt = {yip_r[23:0], b};
        if (rel >= OffW'(244) && rel < OffW'(248) && b != magic_byte(rel[1:0]))
          hok_nxt = 1'b0;
        if (rel >= OffW'(248) && !end_r) begin
          unique case (ph_r)
            PH_TYPE: begin
              if (b == OPT_END) end_nxt = 1'b1;
              else if (b != OPT_PAD) begin
                code_nxt = b;
                ph_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              rem_nxt = b;
              cnt_nxt = '0;
              shift_nxt = '0;
              ph_nxt = (b != 8'h00) ? PH_DATA : PH_TYPE;
            end
            default: begin
              sh = {shift_r[23:0], b};
              cn = (cnt_r == 3'd7) ? cnt_r : cnt_r + 3'd1;
              shift_nxt = sh;
              cnt_nxt = cn;
              if (sz != 3'd0 && cn == sz) begin
                if (code_r == OPT_MSG_TYPE) kind_nxt = sh[7:0];
                else if (slot == 4'd4) begin
                  if (!ns_r) begin
                    cap_nxt[4] = sh;
                    ns_nxt = 1'b1;
                  end
                end else cap_nxt[slot] = sh;
              end
              rem_nxt = rem_r - 8'd1;
              if (rem_nxt == 8'd0) ph_nxt = PH_TYPE;
            end
          endcase
        end
      end
      off_nxt = o + OffW'(1);
    end
    ok = hok_nxt && off_nxt >= OffW'(268) && off_nxt >= ipl + OffW'(248)
         && {4'd0, tlen_nxt} >= 20'({hw_nxt, 2'b00}) + 20'd249;
    status.pkt_end  = step && last_byte;
    status.accepted = ok;
    status.kind     = kind_nxt;
    lease.outcome        = OUT_DISCOVER;
    lease.offered_ip     = yip_nxt;
    lease.net_mask       = cap_nxt[0];
    lease.router_ip      = cap_nxt[1];
    lease.broadcast_ip   = cap_nxt[2];
    lease.server_ip      = cap_nxt[3];
    lease.name_server_ip = cap_nxt[4];
    lease.lease_seconds  = cap_nxt[5];
    lease.renew_seconds  = cap_nxt[6];
    lease.rebind_seconds = cap_nxt[7];
    lease.link_mtu       = cap_nxt[8][15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      off_r <= '0; hw_r <= '0; tlen_r <= '0; hok_r <= 1'b1; ph_r <= PH_TYPE;
      code_r <= '0; rem_r <= '0; shift_r <= '0; cnt_r <= '0; ns_r <= 1'b0;
      yip_r <= '0; kind_r <= '0; end_r <= 1'b0;
      for (int i = 0; i < 9; i++) cap_r[i] <= '0;
    end else if (step) begin
      off_r <= off_nxt; hw_r <= hw_nxt; tlen_r <= tlen_nxt; hok_r <= hok_nxt;
      ph_r <= ph_nxt; code_r <= code_nxt; rem_r <= rem_nxt;
      shift_r <= shift_nxt; cnt_r <= cnt_nxt; ns_r <= ns_nxt;
      yip_r <= yip_nxt; kind_r <= kind_nxt; end_r <= end_nxt;
      for (int i = 0; i < 9; i++) cap_r[i] <= cap_nxt[i];
    end
  end

endmodule

// File: rtl/dhcp_client_fsm.sv
module dhcp_client_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [1:0]            action,
  input  dhcp_pkg::pkt_status_t status,
  input  dhcp_pkg::out_item_t   lease,
  output logic                  res_valid,
  output dhcp_pkg::out_item_t   res
);
  import dhcp_pkg::*;

  client_state_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    if (step) begin
      unique case (action)
        ACT_START: st_nxt = ST_DISCOVER;
        ACT_TIMEOUT:
          if (st_r == ST_DISCOVER || st_r == ST_REQUEST) st_nxt = ST_FAIL;
        ACT_BYTE:
          if (status.pkt_end && status.accepted) begin
            if (st_r == ST_DISCOVER && status.kind == MSG_OFFER) st_nxt = ST_REQUEST;
            else if (st_r == ST_REQUEST && status.kind == MSG_NAK) st_nxt = ST_DISCOVER;
            else if (st_r == ST_REQUEST && status.kind == MSG_ACK) st_nxt = ST_DONE;
          end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res = '0;
    if (step) begin
      unique case (action)
        ACT_START: begin
          res_valid = 1'b1;
          res.outcome = OUT_DISCOVER;
        end
        ACT_TIMEOUT:
          if (st_r == ST_DISCOVER || st_r == ST_REQUEST) begin
            res_valid = 1'b1;
            res.outcome = OUT_FAILED;
          end
        ACT_BYTE:
          if (status.pkt_end && status.accepted) begin
            if (st_r == ST_DISCOVER && status.kind == MSG_OFFER) begin
              res_valid = 1'b1;
              res = lease;
              res.outcome = OUT_REQUEST;
            end else if (st_r == ST_REQUEST && status.kind == MSG_NAK) begin
              res_valid = 1'b1;
              res.outcome = OUT_DISCOVER;
            end else if (st_r == ST_REQUEST && status.kind == MSG_ACK) begin
              res_valid = 1'b1;
              res = lease;
              res.outcome = OUT_LEASE;
            end
          end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_NONE;
    else st_r <= st_nxt;
  end

endmodule

// File: rtl/dhcp_client_reply_parser.sv
// DHCP client reply parser. Feed a received IPv4 packet one byte per item
// (action 0, last_byte on the final byte), or a start / timeout event. An
// accepted item sits in an input register; when it advances, its result is
// registered in the output register. One item per cycle is sustained while
// results are taken; a result held by out_ready low stalls the input. At
// most one result leaves per item, on a start, on a timeout while pending,
// or on the last byte of an accepted offer, ack or nak. Options are decoded
// on the fly as bytes arrive.
module dhcp_client_reply_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dhcp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dhcp_pkg::out_item_t out_data
);
  import dhcp_pkg::*;

  logic        iv_r;
  in_item_t    ib_r;
  logic        step, res_valid, ov_r;
  out_item_t   res, ob_r;
  pkt_status_t status;
  out_item_t   lease;

  // Advance the stage only when the result slot can take what it produces.
  assign step     = iv_r && (!ov_r || out_ready);
  assign in_ready = !iv_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (in_ready) iv_r <= in_valid;
    if (in_ready && in_valid) ib_r <= in_data;
  end

  dhcp_byte_parser u_parser (
    .clk(clk), .rst_n(rst_n), .step(step && ib_r.action == ACT_BYTE),
    .data_byte(ib_r.data_byte), .last_byte(ib_r.last_byte),
    .status(status), .lease(lease)
  );

  dhcp_client_fsm u_fsm (
    .clk(clk), .rst_n(rst_n), .step(step), .action(ib_r.action),
    .status(status), .lease(lease), .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (!ov_r || out_ready) ov_r <= step && res_valid;
    if ((!ov_r || out_ready) && step && res_valid) ob_r <= res;
  end

  assign out_valid = ov_r;
  assign out_data  = ob_r;

endmodule

// File: rtl/dhcp_checker.sv
module dhcp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dhcp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dhcp_pkg::out_item_t out_data
);
  import dhcp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OUT_DISCOVER || out_data.outcome == OUT_FAILED)
    |-> out_data.offered_ip == 32'd0 && out_data.link_mtu == 16'd0)
    else $error("fields set on discover or fail result");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with free result slot");

  // Once the start item can advance, its result shows on the next cycle.
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_START
    ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("start produced no result");

endmodule

bind dhcp_client_reply_parser dhcp_checker u_dhcp_checker (.*);

// File: dv/dhcp_client_reply_parser_tb.sv
module dhcp_client_reply_parser_tb;
  import dhcp_pkg::*;

  // Action code the block ignores.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  dhcp_client_reply_parser DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predictor state
  client_state_t lease_state;
  int unsigned   pkt_off;
  logic [3:0]    ihl_words;
  logic [15:0]   ip_total_len;
  logic          hdr_good;
  opt_phase_t    opt_phase;
  logic [7:0]    opt_code;
  logic [7:0]    opt_left;
  logic [31:0]   opt_value;
  int unsigned   opt_count;
  logic [31:0]   lease_fields [9];
  logic          dns_taken;
  logic [31:0]   yiaddr;
  logic [7:0]    msg_kind;
  logic          opts_done;

  out_item_t     expected_replies [$];
  int            fail_count = 0;
  int            reply_count = 0;
  int            item_count = 0;
  int unsigned   cycle_count = 0;
  logic          idle_enable = 1'b1;
  logic          hold_off = 1'b0;

  function automatic logic [7:0] magic_at(int unsigned idx);
    case (idx)
      0: return 8'h63;
      1: return 8'h82;
      2: return 8'h53;
      default: return 8'h63;
    endcase
  endfunction

  task automatic clear_packet();
    pkt_off = 0; ihl_words = '0; ip_total_len = '0; hdr_good = 1'b1;
    opt_phase = PH_TYPE; opt_code = '0; opt_left = '0; opt_value = '0;
    opt_count = 0; dns_taken = 1'b0; yiaddr = '0; msg_kind = '0;
    opts_done = 1'b0;
    for (int i = 0; i < 9; i++) lease_fields[i] = '0;
  endtask

  task automatic walk_option(logic [7:0] b);
    int slot;
    int unsigned vsize;
    slot = 9;
    vsize = 4;
    if (opt_phase == PH_TYPE) begin
      if (b == OPT_END) opts_done = 1'b1;
      else if (b != OPT_PAD) begin
        opt_code = b;
        opt_phase = PH_LEN;
      end
    end else if (opt_phase == PH_LEN) begin
      opt_left = b;
      opt_count = 0;
      opt_value = '0;
      opt_phase = (b != 0) ? PH_DATA : PH_TYPE;
    end else begin
      opt_value = {opt_value[23:0], b};
      opt_count++;
      case (opt_code)
        OPT_MASK: slot = 0;
        OPT_ROUTER: slot = 1;
        OPT_BCAST: slot = 2;
        OPT_SERVER: slot = 3;
        OPT_NAME_SRV: slot = 4;
        OPT_LEASE: slot = 5;
        OPT_RENEW: slot = 6;
        OPT_REBIND: slot = 7;
        OPT_MTU: begin slot = 8; vsize = 2; end
        OPT_MSG_TYPE: vsize = 1;
        default: vsize = 0;
      endcase
      if (vsize != 0 && opt_count == vsize) begin
        if (opt_code == OPT_MSG_TYPE) msg_kind = opt_value[7:0];
        else if (slot == 4) begin
          if (!dns_taken) begin
            lease_fields[4] = opt_value;
            dns_taken = 1'b1;
          end
        end else if (slot < 9) lease_fields[slot] = opt_value;
      end
      opt_left = opt_left - 8'd1;
      if (opt_left == 0) opt_phase = PH_TYPE;
    end
  endtask

  task automatic parse_byte(logic [7:0] b);
    int unsigned ipl;
    if (pkt_off >= MaxPacketBytes) return;
    if (pkt_off == 0) ihl_words = b[3:0];
    ipl = ihl_words * 4;
    if (pkt_off == 2) ip_total_len[15:8] = b;
    if (pkt_off == 3) ip_total_len[7:0] = b;
    if (pkt_off == 9 && b != UDP_PROTO) hdr_good = 1'b0;
    if (pkt_off == ipl + 2 && b != 8'd0) hdr_good = 1'b0;
    if (pkt_off == ipl + 3 && b != BOOTPC_PORT) hdr_good = 1'b0;
    if (pkt_off >= ipl + 24 && pkt_off < ipl + 28) yiaddr = {yiaddr[23:0], b};
    if (pkt_off >= ipl + 244 && pkt_off < ipl + 248 && b != magic_at(pkt_off - ipl - 244))
      hdr_good = 1'b0;
    if (pkt_off >= ipl + 248 && !opts_done) walk_option(b);
    pkt_off++;
  endtask

  function automatic out_item_t lease_reply(logic [1:0] oc);
    out_item_t r;
    r = '0;
    r.outcome = oc;
    r.offered_ip = yiaddr;
    r.net_mask = lease_fields[0];
    r.router_ip = lease_fields[1];
    r.broadcast_ip = lease_fields[2];
    r.server_ip = lease_fields[3];
    r.name_server_ip = lease_fields[4];
    r.lease_seconds = lease_fields[5];
    r.renew_seconds = lease_fields[6];
    r.rebind_seconds = lease_fields[7];
    r.link_mtu = lease_fields[8][15:0];
    return r;
  endfunction

  task automatic predict_reply(in_item_t it);
    out_item_t r;
    int unsigned ipl;
    r = '0;
    if (it.action == ACT_START) begin
      lease_state = ST_DISCOVER;
      r.outcome = OUT_DISCOVER;
      expected_replies.push_back(r);
    end else if (it.action == ACT_TIMEOUT) begin
      if (lease_state == ST_DISCOVER || lease_state == ST_REQUEST) begin
        lease_state = ST_FAIL;
        r.outcome = OUT_FAILED;
        expected_replies.push_back(r);
      end
    end else if (it.action == ACT_BYTE) begin
      parse_byte(it.data_byte);
      if (it.last_byte) begin
        ipl = ihl_words * 4;
        if (hdr_good && pkt_off >= 268 && pkt_off >= ipl + 248 && ip_total_len >= ipl + 249)
        begin
          if (lease_state == ST_DISCOVER && msg_kind == MSG_OFFER) begin
            lease_state = ST_REQUEST;
            expected_replies.push_back(lease_reply(OUT_REQUEST));
          end else if (lease_state == ST_REQUEST && msg_kind == MSG_NAK) begin
            lease_state = ST_DISCOVER;
            r.outcome = OUT_DISCOVER;
            expected_replies.push_back(r);
          end else if (lease_state == ST_REQUEST && msg_kind == MSG_ACK) begin
            lease_state = ST_DONE;
            expected_replies.push_back(lease_reply(OUT_LEASE));
          end
        end
        clear_packet();
      end
    end
  endtask

  // Send one item; predict it at acceptance.
  task automatic send_item(logic [1:0] act, logic [7:0] b, logic last);
    in_item_t it;
    it.action = act;
    it.data_byte = b;
    it.last_byte = last;
    if (idle_enable && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_reply(it);
    item_count++;
  endtask

  task automatic pause_output();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Packet builder
  logic [7:0] pkt [$];

  task automatic build_reply(logic [7:0] kind, bit good, int unsigned ihl, int unsigned extra);
    int unsigned ipl;
    logic [15:0] tl;
    pkt.delete();
    ipl = ihl * 4;
    for (int i = 0; i < ipl + 248; i++) pkt.push_back(8'($urandom_range(0, 255)));
    pkt[0] = {4'h4, ihl[3:0]};
    pkt[9] = UDP_PROTO;
    pkt[ipl + 2] = 8'd0;
    pkt[ipl + 3] = BOOTPC_PORT;
    for (int i = 0; i < 4; i++) pkt[ipl + 244 + i] = magic_at(i);
    pkt.push_back(OPT_MSG_TYPE); pkt.push_back(8'd1); pkt.push_back(kind);
    for (int k = 0; k < extra; k++) begin
      case ($urandom_range(0, 13))
        0: pkt.push_back(OPT_PAD);
        1: begin
          pkt.push_back(OPT_MTU); pkt.push_back(8'd2);
          pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
        end
        2: begin
          pkt.push_back(8'($urandom_range(0, 255)));
          pkt.push_back(8'($urandom_range(0, 3)));
        end
        default: begin
          case ($urandom_range(0, 8))
            0: pkt.push_back(OPT_MASK);
            1: pkt.push_back(OPT_ROUTER);
            2: pkt.push_back(OPT_BCAST);
            3: pkt.push_back(OPT_SERVER);
            4: pkt.push_back(OPT_NAME_SRV);
            5: pkt.push_back(OPT_LEASE);
            6: pkt.push_back(OPT_RENEW);
            7: pkt.push_back(OPT_REBIND);
            default: pkt.push_back(OPT_MSG_TYPE);
          endcase
          begin
            int unsigned n;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
            pkt.push_back(n[7:0]);
            for (int j = 0; j < n; j++) pkt.push_back(8'($urandom));
          end
        end
      endcase
    end
    if ($urandom_range(0, 1)) pkt.push_back(OPT_END);
    while (pkt.size() < 268) pkt.push_back(8'($urandom));
    tl = 16'(pkt.size());
    pkt[2] = tl[15:8];
    pkt[3] = tl[7:0];
    if (!good) begin
      case ($urandom_range(0, 4))
        0: pkt[9] = 8'($urandom_range(18, 255));
        1: pkt[ipl + 3] = 8'd67;
        2: pkt[ipl + 245] = 8'h00;
        3: begin pkt[2] = 8'd0; pkt[3] = 8'd10; end
        default: pkt = pkt[0:200];
      endcase
    end
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_item(ACT_BYTE, pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_drained();
    pause_output();
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Output side
  always @(posedge clk) begin
    if (rst_n && !hold_off)
      out_ready <= (idle_enable && $urandom_range(0, 5) == 0) ? 1'b0 : 1'b1;
    else if (hold_off)
      out_ready <= 1'b0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      reply_count++;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_events();
    send_item(ACT_TIMEOUT, 8'h00, 1'b0);
    send_item(ACT_UNUSED, 8'hFF, 1'b1);
    send_item(ACT_START, 8'hFF, 1'b1);
    send_item(ACT_START, 8'h00, 1'b0);
    send_item(ACT_TIMEOUT, 8'hFF, 1'b1);
    send_item(ACT_TIMEOUT, 8'h00, 1'b0);
  endtask

  task automatic test_handshake_flow();
    send_item(ACT_START, 8'h00, 1'b0);
    build_reply(MSG_OFFER, 1, 5, 6);  send_packet();
    build_reply(MSG_ACK, 1, 6, 8);    send_packet();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 8; i++) begin
          send_item(ACT_START, 8'h00, 1'b0);
          send_item(ACT_TIMEOUT, 8'h00, 1'b0);
        end
      end
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic test_random(int unsigned total);
    while (item_count < total) begin
      case ($urandom_range(0, 9))
        0: send_item(ACT_START, 8'($urandom), 1'($urandom));
        1: send_item(ACT_TIMEOUT, 8'($urandom), 1'($urandom));
        2: send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        3: begin
          build_reply(8'($urandom_range(0, 8)), 0, $urandom_range(5, 8), 3);
          send_packet();
        end
        default: begin
          if (lease_state != ST_DISCOVER && lease_state != ST_REQUEST)
            send_item(ACT_START, 8'h00, 1'b0);
          build_reply(lease_state == ST_DISCOVER ? MSG_OFFER :
                      ($urandom_range(0, 3) == 0 ? MSG_NAK : MSG_ACK),
                      1, $urandom_range(5, 7), $urandom_range(0, 10));
          send_packet();
        end
      endcase
    end
  endtask

  initial begin
    lease_state = ST_NONE;
    clear_packet();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_events();
    test_handshake_flow();
    test_backpressure();
    test_random(item_count + 200);
    idle_enable = 1'b0;
    test_random(item_count + 150);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Ran %0d items through start, timeout, offer/ack/nak, malformed and cut-off",
             item_count);
    $display("packets and a long result stall; %0d results checked.", reply_count);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dhcp_pkg.sv
rtl/dhcp_byte_parser.sv
rtl/dhcp_client_fsm.sv
rtl/dhcp_client_reply_parser.sv
rtl/dhcp_checker.sv
dv/dhcp_client_reply_parser_tb.sv
